### rtl/core/dtsp_pkg.sv
// Package for the dual triangle slip pulse generator.
// Holds shared constants; no dependencies.
package dtsp_pkg;
    localparam int unsigned SAMPLE_INTERVAL_RESET = 256;
    localparam int unsigned RECORD_LENGTH_RESET   = 64;
    localparam logic [16:0] BETA_DEEP   = 17'd13107;
    localparam logic [16:0] BETA_SHAL   = 17'd32768;
    localparam logic [15:0] DEPTH_MIN   = 16'd1024;
    localparam logic [15:0] DEPTH_MAX   = 16'd1536;
    localparam logic [14:0] BETA_SLOPE  = 15'd19661;
    localparam logic        CFG_IDX_DT  = 1'b0;
    localparam logic        CFG_IDX_NT  = 1'b1;
endpackage

### rtl/core/dtsp_if.sv
// Valid/ready channel interfaces for the pulse generator.
// Depends on nothing; payload widths are those of the block's fields.
interface dtsp_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] rise_time;
    logic [23:0] slip_amount;
    logic [15:0] source_depth;
    modport source (output valid, rise_time, slip_amount, source_depth, input ready);
    modport sink   (input valid, rise_time, slip_amount, source_depth, output ready);
endinterface

interface dtsp_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  sample_index;
    logic [31:0] sample_value;
    logic        last;
    logic        empty_res;
    modport source (output valid, sample_index, sample_value, last, empty_res, input ready);
    modport sink   (input valid, sample_index, sample_value, last, empty_res, output ready);
endinterface

interface dtsp_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/dual_triangle_slip_pulse_generator_top.sv
// Dual triangle slip pulse generator: sequencer around one shared divider.
// Uses dtsp_pkg and the channel interfaces in dtsp_if.sv.
// Sequence: two 64-step divisions for the interval counts, then per sample
//   one 64-step division to build it and one to scale and emit it.
// Throughput: one item at a time, plus any output stalls.
// Reset: asynchronous active low; registers return to dt = 256, nt = 64.
module dual_triangle_slip_pulse_generator_top #(
    parameter int unsigned MAX_SAMPLES = 64
) (
    input logic clk,
    input logic rst_n,
    dtsp_cfg_if.sink  cfg,
    dtsp_in_if.sink   in_ch,
    dtsp_out_if.source out_ch
);
    import dtsp_pkg::*;

    localparam int unsigned IW = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned AW = $clog2(MAX_SAMPLES);
    localparam int unsigned SW = 17 + IW;
    // Sample counts reach 65535 for the rise time and stay below twice it0 for it2.
    localparam int unsigned TW = 17;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_PREP, S_SUM, S_SDIV, S_SCHK, S_SCALE, S_SOUT, S_WAIT
    } state_t;
    typedef enum logic [2:0] {
        D_IT0, D_IT1, D_UP, D_DN, D_TAIL, D_OUT
    } dsel_t;

    state_t state_reg;
    dsel_t  dsel_reg;
    logic [15:0] dt_reg;
    logic [6:0]  nt_reg;
    logic [23:0] slip_reg;
    logic [15:0] tr_reg;
    logic [16:0] beta_reg;
    logic [TW-1:0] it0_reg, it1_reg, it2_reg;
    logic [IW:0] k_reg, count_reg;
    logic [SW-1:0] sum_reg;
    logic [16:0] u_reg;
    logic [63:0] num_reg, quo_reg;
    logic [63:0] rem_reg;
    logic [63:0] den_reg;
    logic [6:0]  step_reg;
    logic [31:0] buf_mem [MAX_SAMPLES];
    logic [31:0] rd_reg;
    logic        ovalid_reg, olast_reg, oempty_reg;
    logic [5:0]  oidx_reg;
    logic [31:0] oval_reg;

    // Shared restoring divider step.
    logic [64:0] trial;
    logic [63:0] rem_sh;
    always_comb
    begin
        rem_sh = {rem_reg[62:0], num_reg[63]};
        trial  = {1'b0, rem_sh} - {1'b0, den_reg};
    end

    // Beta from depth, linear between shallow and deep limits.
    logic [16:0] beta_c;
    logic [31:0] bprod;
    always_comb
    begin
        bprod = 32'(DEPTH_MAX - in_ch.source_depth) * 32'(BETA_SLOPE) + 32'd256;
        if (in_ch.source_depth >= DEPTH_MAX)
            beta_c = BETA_DEEP;
        else if (in_ch.source_depth > DEPTH_MIN)
            beta_c = BETA_DEEP + 17'(bprod >> 9);
        else
            beta_c = BETA_SHAL;
    end

    logic [15:0] dt_eff;
    logic [IW:0] nt_eff;
    assign dt_eff = (dt_reg == 16'd0) ? 16'd1 : dt_reg;
    assign nt_eff = (32'(nt_reg) > MAX_SAMPLES) ? (IW+1)'(MAX_SAMPLES) : (IW+1)'(nt_reg);

    // it2 = ((2 - beta) * it0) >> 16, narrow multiply.
    logic [40:0] it2_prod;
    assign it2_prod = 41'(18'(18'h20000 - 18'(beta_reg))) * 41'(it0_reg);

    // Region selection for the current sample.
    logic [TW-1:0] kx;
    assign kx = TW'(k_reg);

    assign cfg.ready     = (state_reg == S_IDLE) && !ovalid_reg;
    assign in_ch.ready   = (state_reg == S_IDLE) && !ovalid_reg;
    assign out_ch.valid        = ovalid_reg;
    assign out_ch.sample_index = oidx_reg;
    assign out_ch.sample_value = oval_reg;
    assign out_ch.last         = olast_reg;
    assign out_ch.empty_res    = oempty_reg;

    // Sample memory, read data registered.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_SUM && step_reg == 7'd0 && dsel_reg != D_IT1)
            buf_mem[k_reg[AW-1:0]] <= {15'd0, u_reg};
        rd_reg <= buf_mem[k_reg[AW-1:0]];
    end

    // Sequencer and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            dsel_reg   <= D_IT0;
            dt_reg     <= 16'(SAMPLE_INTERVAL_RESET);
            nt_reg     <= 7'(RECORD_LENGTH_RESET);
            ovalid_reg <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            if (ovalid_reg && out_ch.ready)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg.valid && cfg.ready)
                    begin
                        if (cfg.index == CFG_IDX_DT)
                            dt_reg <= cfg.data;
                        else
                            nt_reg <= cfg.data[6:0];
                    end
                    if (in_ch.valid && in_ch.ready)
                    begin
                        tr_reg   <= in_ch.rise_time;
                        slip_reg <= in_ch.slip_amount;
                        beta_reg <= beta_c;
                        if (nt_eff == '0)
                        begin
                            ovalid_reg <= 1'b1; oidx_reg <= '0; oval_reg <= '0;
                            olast_reg <= 1'b1; oempty_reg <= 1'b1;
                        end
                        else
                        begin
                            num_reg  <= 64'(in_ch.rise_time) + 64'(5 * 32'(dt_eff));
                            den_reg  <= 64'(10 * 32'(dt_eff));
                            rem_reg  <= '0;
                            step_reg <= 7'd64;
                            dsel_reg <= D_IT0;
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV:
                begin
                    // One quotient bit per cycle.
                    if (step_reg != 7'd0)
                    begin
                        if (!trial[64])
                            rem_reg <= trial[63:0];
                        else
                            rem_reg <= rem_sh;
                        num_reg  <= {num_reg[62:0], ~trial[64]};
                        step_reg <= step_reg - 7'd1;
                    end
                    else
                    begin
                        quo_reg <= num_reg;
                        unique case (dsel_reg)
                            D_IT0:
                            begin
                                it0_reg  <= (num_reg < 64'd2) ? TW'(2) : TW'(num_reg);
                                num_reg  <= 64'({tr_reg, 1'b0}) + 64'(dt_eff);
                                den_reg  <= 64'({dt_eff, 1'b0});
                                rem_reg  <= '0;
                                step_reg <= 7'd64;
                                dsel_reg <= D_IT1;
                            end
                            D_IT1:
                            begin
                                it1_reg  <= (num_reg < 64'd4) ? TW'(4) : TW'(num_reg);
                                state_reg <= S_PREP;
                            end
                            D_OUT:
                            begin
                                state_reg <= S_SOUT;
                            end
                            default:
                            begin
                                u_reg    <= 17'(num_reg);
                                sum_reg  <= sum_reg + SW'(num_reg[16:0]);
                                step_reg <= '0;
                                state_reg <= S_SUM;
                            end
                        endcase
                    end
                end
                S_PREP:
                begin
                    logic [TW-1:0] endv, lnz;
                    it2_reg <= TW'(it2_prod >> 16);
                    endv = (TW'(it2_prod >> 16) > it1_reg) ?
                        TW'(it2_prod >> 16) : it1_reg;
                    lnz = endv - 1'b1;
                    if (lnz > TW'(nt_eff) - 1'b1)
                        lnz = TW'(nt_eff) - 1'b1;
                    if (lnz == '0)
                    begin
                        ovalid_reg <= 1'b1; oidx_reg <= '0; oval_reg <= '0;
                        olast_reg <= 1'b1; oempty_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        count_reg <= (lnz < TW'(nt_eff) - 1'b1) ?
                            (IW+1)'(lnz + 2'd2) : (IW+1)'(lnz);
                        k_reg    <= '0;
                        sum_reg  <= '0;
                        dsel_reg <= D_IT1;
                        step_reg <= 7'd1;
                        state_reg <= S_SUM;
                    end
                end
                S_SUM:
                begin
                    // step 1: start division for sample k; step 0: advance.
                    if (step_reg == 7'd0)
                    begin
                        if (k_reg + 1'b1 == count_reg)
                            state_reg <= S_SCHK;
                        else
                        begin
                            k_reg <= k_reg + 1'b1;
                            step_reg <= 7'd1;
                        end
                    end
                    else
                    begin
                        rem_reg  <= '0;
                        step_reg <= 7'd64;
                        state_reg <= S_DIV;
                        if (kx < it0_reg)
                        begin
                            num_reg <= 64'(kx) << 16; den_reg <= 64'(it0_reg);
                            dsel_reg <= D_UP;
                        end
                        else if (kx < it2_reg)
                        begin
                            num_reg <= (64'(it0_reg) + 64'(it0_reg) - 64'(kx)) << 16;
                            den_reg <= 64'(it0_reg);
                            dsel_reg <= D_DN;
                        end
                        else if (kx < it1_reg)
                        begin
                            num_reg <= 64'(beta_reg) * 64'(it1_reg - kx);
                            den_reg <= 64'(it1_reg - it2_reg);
                            dsel_reg <= D_TAIL;
                        end
                        else
                        begin
                            num_reg <= '0; den_reg <= 64'd1;
                            dsel_reg <= D_TAIL;
                        end
                    end
                end
                S_SCHK:
                begin
                    if (sum_reg == '0)
                    begin
                        ovalid_reg <= 1'b1; oidx_reg <= '0; oval_reg <= '0;
                        olast_reg <= 1'b1; oempty_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        den_reg  <= 64'(dt_eff) * 64'(sum_reg);
                        k_reg    <= '0;
                        step_reg <= 7'd0;
                        state_reg <= S_SCALE;
                    end
                end
                S_SCALE:
                begin
                    // Wait for the registered memory read.
                    if (step_reg == 7'd0)
                        step_reg <= 7'd1;
                    else
                    begin
                        num_reg  <= 64'({slip_reg, 16'd0}) * 64'(rd_reg[16:0]);
                        rem_reg  <= '0;
                        step_reg <= 7'd64;
                        dsel_reg <= D_OUT;
                        state_reg <= S_DIV;
                    end
                end
                S_SOUT:
                begin
                    ovalid_reg <= 1'b1;
                    oidx_reg   <= k_reg[5:0];
                    oval_reg   <= (quo_reg[63:32] != '0) ? 32'hFFFFFFFF : quo_reg[31:0];
                    olast_reg  <= (k_reg + 1'b1 == count_reg);
                    oempty_reg <= 1'b0;
                    state_reg  <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (out_ch.ready)
                    begin
                        if (olast_reg)
                            state_reg <= S_IDLE;
                        else
                        begin
                            k_reg <= k_reg + 1'b1;
                            step_reg <= 7'd0;
                            state_reg <= S_SCALE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

### rtl/core/dtsp_checker.sv
// Port-level checker for the pulse generator, bound to the top level.
// Depends only on the top level's ports.
module dtsp_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_last,
    input logic out_empty,
    input logic [31:0] out_value
);
    // An empty result is always a single zero item with last set.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_empty |-> out_last && out_value == 32'd0)
        else $error("empty item malformed");
    // No input accepted while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while output pending");
    // After an accepted input the block is busy next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("block not busy after accept");
    // Stalled output holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value))
        else $error("stalled output changed");
endmodule

bind dual_triangle_slip_pulse_generator_top dtsp_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_last(out_ch.last), .out_empty(out_ch.empty_res),
    .out_value(out_ch.sample_value)
);

### tb/pulse_checker.sv
`timescale 1ns / 1ps
// Checker for the dual triangle slip pulse generator: watches all three channels,
// predicts every sample of each pulse and compares. Uses dtsp_pkg and dtsp_if.sv.
module pulse_checker (
    input  logic       clk,
    input  logic       rst_n,
    dtsp_cfg_if        cfg,
    dtsp_in_if         in_ch,
    dtsp_out_if        out_ch,
    output int         errors,
    output int         pending
);
    import dtsp_pkg::*;

    typedef struct packed {
        logic [5:0]  idx;
        logic [31:0] value;
        logic        last;
        logic        empty;
    } sample_t;

    sample_t         expected_samples[$];
    logic [15:0]     dt_reg;
    logic [6:0]      nt_reg;
    int              error_count;

    assign errors  = error_count;
    assign pending = expected_samples.size();

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // Builds the pulse of one patch and queues its samples.
    function automatic void predict_pulse(logic [15:0] tr_in, logic [23:0] slip_in,
                                          logic [15:0] z_in);
        longint unsigned dt, nt, tr, slip, z, beta, it0, it1, it2, pulse_end, last_nz;
        longint unsigned count, sum, den, v;
        longint unsigned u[64];
        sample_t s;
        dt   = (dt_reg == 0) ? 1 : dt_reg;
        nt   = (nt_reg > 64) ? 64 : nt_reg;
        tr   = tr_in;
        slip = slip_in;
        z    = z_in;
        s    = '{idx: 6'd0, value: 32'd0, last: 1'b1, empty: 1'b1};
        if (nt == 0)
        begin
            expected_samples.push_back(s);
            return;
        end
        // Ramp height from depth: shallow, deep, or linear in between.
        if (z >= DEPTH_MAX)
            beta = BETA_DEEP;
        else if (z > DEPTH_MIN)
            beta = BETA_DEEP + (((DEPTH_MAX - z) * BETA_SLOPE + 256) >> 9);
        else
            beta = BETA_SHAL;
        it0 = (tr + 5 * dt) / (10 * dt);
        if (it0 < 2)
            it0 = 2;
        it1 = (2 * tr + dt) / (2 * dt);
        if (it1 < 4)
            it1 = 4;
        it2 = ((131072 - beta) * it0) >> 16;
        pulse_end = (it1 > it2) ? it1 : it2;
        last_nz = pulse_end - 1;
        if (last_nz > nt - 1)
            last_nz = nt - 1;
        if (last_nz == 0)
        begin
            expected_samples.push_back(s);
            return;
        end
        count = (last_nz < nt - 1) ? last_nz + 2 : last_nz;
        sum = 0;
        for (int k = 0; k < count; k++)
        begin
            if (k < it0)
                u[k] = (longint'(k) << 16) / it0;
            else if (k < it2)
                u[k] = ((2 * it0 - k) << 16) / it0;
            else if (k < it1)
                u[k] = (beta * (it1 - k)) / (it1 - it2);
            else
                u[k] = 0;
            sum += u[k];
        end
        if (sum == 0)
        begin
            expected_samples.push_back(s);
            return;
        end
        // Scale so that dt times the area equals the slip, saturating.
        den = dt * sum;
        for (int k = 0; k < count; k++)
        begin
            v = ((slip << 16) * u[k]) / den;
            if (v > 64'hFFFF_FFFF)
                v = 64'hFFFF_FFFF;
            s.idx   = k[5:0];
            s.value = v[31:0];
            s.last  = (k + 1 == count);
            s.empty = 1'b0;
            expected_samples.push_back(s);
        end
    endfunction

    // Tracks register writes, predicts on each accepted item, checks each result.
    always @(posedge clk or negedge rst_n)
    begin
        sample_t want;
        if (!rst_n)
        begin
            dt_reg <= 16'(SAMPLE_INTERVAL_RESET);
            nt_reg <= 7'(RECORD_LENGTH_RESET);
            expected_samples.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_IDX_DT)
                    dt_reg <= cfg.data;
                else
                    nt_reg <= cfg.data[6:0];
            end
            if (in_ch.valid && in_ch.ready)
                predict_pulse(in_ch.rise_time, in_ch.slip_amount, in_ch.source_depth);
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_samples.size() == 0)
                    report_mismatch("unexpected item, index", out_ch.sample_index, 0);
                else
                begin
                    want = expected_samples.pop_front();
                    if (out_ch.sample_index !== want.idx)
                        report_mismatch("sample_index", out_ch.sample_index, want.idx);
                    if (out_ch.sample_value !== want.value)
                        report_mismatch("sample_value", out_ch.sample_value, want.value);
                    if (out_ch.last !== want.last)
                        report_mismatch("last", out_ch.last, want.last);
                    if (out_ch.empty_res !== want.empty)
                        report_mismatch("empty_res", out_ch.empty_res, want.empty);
                end
            end
        end
    end

    initial error_count = 0;
endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Top of the pulse generator testbench: clock, reset, stimulus and verdict.
// Depends on dtsp_pkg, dtsp_if.sv, the block and pulse_checker.
module testbench;
    import dtsp_pkg::*;

    localparam int STALL_LIMIT = 40000;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   phase_dt;
    int   phase_nt;
    bit   no_idle;
    bit   hold_off_req;

    dtsp_cfg_if cfg_ch ();
    dtsp_in_if  in_ch ();
    dtsp_out_if out_ch ();

    dual_triangle_slip_pulse_generator_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    pulse_checker pulse_chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 19);
        if (no_idle || r < 12)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Writes one register and waits for the write to be taken.
    task automatic write_reg(logic idx, logic [15:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stops offering items, waits for the block to drain, then sets the
    // interval and record length.
    task automatic set_phase(int dt, int nt);
        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        write_reg(CFG_IDX_DT, dt[15:0]);
        write_reg(CFG_IDX_NT, nt[15:0]);
        phase_dt = (dt == 0) ? 1 : dt;
        phase_nt = (nt > 64) ? 64 : nt;
    endtask

    // Offers one patch; valid stays high into the next item when there is no gap.
    task automatic send_patch(logic [15:0] tr, logic [23:0] slip, logic [15:0] z);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.rise_time    <= tr;
        in_ch.slip_amount  <= slip;
        in_ch.source_depth <= z;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // Random patch, with the rise time mostly within twice the record length.
    task automatic send_random();
        logic [15:0] tr;
        logic [23:0] slip;
        logic [15:0] z;
        longint      span;
        span = longint'(phase_dt) * phase_nt * 2;
        if (span > 65535)
            span = 65535;
        if ($urandom_range(0, 3) == 0)
            tr = 16'($urandom);
        else
            tr = 16'($urandom_range(0, int'(span)));
        slip = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(0, 4096)) : 24'($urandom);
        z    = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(900, 1700));
        send_patch(tr, slip, z);
    endtask

    task automatic random_phase(int dt, int nt, int items);
        set_phase(dt, nt);
        no_idle = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < items; i++)
            send_random();
        no_idle = 1'b0;
    endtask

    // Output side: random stalls, now and then a long one, plus one long
    // hold-off on request.
    initial
    begin
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (3000) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else if (no_idle)
                out_ch.ready <= 1'b1;
            else if ($urandom_range(0, 49) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(10, 60)) @(posedge clk);
            end
            else
                out_ch.ready <= ($urandom_range(0, 19) < 14);
        end
    end

    // Watchdog on cycles in which no channel moves anything.
    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("dual_triangle_slip_pulse_generator_top: mismatch");
                $finish;
            end
        end
    end

    // Main sequence.
    initial
    begin
        logic [15:0] depths[11];
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= CFG_IDX_DT;
        cfg_ch.data         <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.rise_time     <= '0;
        in_ch.slip_amount   <= '0;
        in_ch.source_depth  <= '0;
        no_idle             = 1'b0;
        hold_off_req        = 1'b0;
        phase_dt            = SAMPLE_INTERVAL_RESET;
        phase_nt            = RECORD_LENGTH_RESET;
        rst_n               <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, field extremes and depth breakpoints.
        depths = '{16'd0, 16'd1023, 16'd1024, 16'd1025, 16'd1280, 16'd1535,
                   16'd1536, 16'd1537, 16'd4000, 16'hFFFF, 16'hAAAA};
        send_patch(16'd0, 24'd0, 16'd0);
        send_patch(16'hFFFF, 24'hFFFFFF, 16'hFFFF);
        send_patch(16'd0, 24'hFFFFFF, 16'd0);
        for (int i = 0; i < 11; i++)
            send_patch(16'd2560 + 16'(i * 512), 24'h5555AA, depths[i]);
        // Full-length pulse on a short record, and a short one at full slip.
        set_phase(256, 8);
        send_patch(16'hFFFF, 24'h123456, 16'd1200);
        send_patch(16'd1024, 24'hFFFFFF, 16'd0);
        // Record of one sample and of none give empty pulses.
        set_phase(256, 1);
        send_patch(16'd5000, 24'h000100, 16'd800);
        set_phase(0, 0);
        send_patch(16'd5000, 24'h000100, 16'd800);
        // Zero interval and a record longer than the buffer.
        set_phase(0, 6);
        send_patch(16'd3, 24'hFFFFFF, 16'd1500);
        set_phase(65535, 127);
        send_patch(16'hFFFF, 24'h0000FF, 16'd0);

        // Random phases; the long hold-off falls in the first.
        hold_off_req = 1'b1;
        random_phase(256, 8, 60);
        random_phase(1, 5, 50);
        random_phase(65535, 16, 20);
        random_phase(100, 1, 20);
        random_phase(128, 0, 15);
        random_phase(300, 127, 8);
        random_phase(64, 12, 50);
        random_phase(1000, 4, 50);
        random_phase(0, 3, 40);
        random_phase(20, 7, 50);
        random_phase(512, 64, 8);
        random_phase(37, 2, 30);
        in_ch.valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("dual_triangle_slip_pulse_generator_top: match");
        else
            $display("dual_triangle_slip_pulse_generator_top: mismatch");
        $finish;
    end
endmodule
